@@ rtl/core/vfa_pkg.sv @@
// shared types and constants for the 3d vector fixed point alu
`default_nettype none

package vfa_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned QUOT_BITS = 32;
  localparam int unsigned IN_DATA_W  = 224;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_MAG   = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    op_t                           op;
    logic                          s_zero;
    logic [2:0][WORD_W-1:0]        a;
    logic [2:0][WORD_W-1:0]        b;
    logic [WORD_W-1:0]             s;
  } item_t;

  typedef struct packed {
    op_t                           op;
    logic                          s_zero;
    logic [2:0][WORD_W-1:0]        a;
    logic [WORD_W-1:0]             s;
  } ctx_t;

endpackage

`default_nettype wire

@@ rtl/core/vfa_front.sv @@
// front end: takes input transactions and classifies them for the queue
`default_nettype none

module vfa_front
  import vfa_pkg::*;
(
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  output logic                       q_wr,
  output item_t                      q_item,
  input  wire logic                  q_full
);

  assign s_tready = !q_full;
  assign q_wr     = s_tvalid && !q_full;

  always_comb begin
    q_item.op     = op_t'(s_tuser);
    q_item.a[0]   = s_tdata[31:0];
    q_item.a[1]   = s_tdata[63:32];
    q_item.a[2]   = s_tdata[95:64];
    q_item.b[0]   = s_tdata[127:96];
    q_item.b[1]   = s_tdata[159:128];
    q_item.b[2]   = s_tdata[191:160];
    q_item.s      = s_tdata[223:192];
    q_item.s_zero = (s_tdata[223:192] == '0);
  end

endmodule

`default_nettype wire

@@ rtl/core/vfa_queue.sv @@
// two-entry queue between front end and execution pipeline
`default_nettype none

module vfa_queue
  import vfa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire item_t wdata,
  output logic       full,
  input  wire logic  rd,
  output item_t      rdata,
  output logic       valid
);

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vfa_back.sv @@
// execution pipeline: multiply, round, square root, divide, saturate
`default_nettype none

module vfa_back
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire item_t                  q_item,
  output logic                        q_rd,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,
  output logic [OUT_USER_W-1:0]       m_tuser
);

  typedef struct packed {
    ctx_t                   ctx;
    logic [2:0][WORD_W-1:0] r;
    logic [WORD_W-1:0]      sc;
    logic                   sat;
  } car_t;

  typedef struct packed {
    logic [PROD_W-1:0] n;
    logic [PROD_W-1:0] r;
    car_t              car;
  } sq_t;

  typedef struct packed {
    logic [2:0][PROD_W-1:0]    rem;
    logic [2:0][QUOT_BITS-1:0] q;
    logic [2:0]                ovf;
    logic [2:0]                neg;
    logic [WORD_W-1:0]         d;
    logic                      mzero;
    car_t                      car;
  } dv_t;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
  localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);

  function automatic logic [32:0] sat_fn(input logic signed [65:0] v);
    if (v > SAT_HI) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < SAT_LO) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [32:0] round_fn(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    return sat_fn(t);
  endfunction

  function automatic logic signed [65:0] ext32(input logic [31:0] x);
    return {{34{x[31]}}, x};
  endfunction

  function automatic logic signed [65:0] ext64(input logic [63:0] x);
    return {{2{x[63]}}, x};
  endfunction

  logic adv;
  assign adv  = !m_tvalid || m_tready;
  assign q_rd = adv && q_valid;

  // stage 1: products
  logic signed [WORD_W-1:0] ml [6];
  logic signed [WORD_W-1:0] mr [6];
  logic signed [PROD_W-1:0] s1_p [6];
  ctx_t                     s1_ctx;
  logic [2:0][WORD_W-1:0]   s1_b;
  logic                     s1_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ml[i]   = q_item.a[i];
      mr[i]   = q_item.a[i];
      ml[3+i] = q_item.a[(i+2)%3];
      mr[3+i] = q_item.b[(i+1)%3];
      case (q_item.op)
        OP_SCALE: mr[i] = q_item.s;
        OP_DOT:   mr[i] = q_item.b[i];
        OP_CROSS: begin
          ml[i] = q_item.a[(i+1)%3];
          mr[i] = q_item.b[(i+2)%3];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        s1_p[i] <= ml[i] * mr[i];
      end
      s1_ctx.op     <= q_item.op;
      s1_ctx.s_zero <= q_item.s_zero;
      s1_ctx.a      <= q_item.a;
      s1_ctx.s      <= q_item.s;
      s1_b          <= q_item.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= q_valid;
    end
  end

  // stage 2: sums, rounding, saturation, sum of squares
  car_t              c2;
  logic [PROD_W-1:0] sq2;
  logic [32:0]       t2 [3];
  logic [32:0]       d2;

  sq_t  sq_st [SQRT_STEPS+1];
  logic sq_v  [SQRT_STEPS+1];

  always_comb begin
    c2     = '0;
    c2.ctx = s1_ctx;
    sq2    = s1_p[0] + s1_p[1] + s1_p[2];
    d2     = round_fn(ext64(s1_p[0]) + ext64(s1_p[1]) + ext64(s1_p[2]));
    for (int i = 0; i < 3; i++) begin
      t2[i] = '0;
      case (s1_ctx.op)
        OP_ADD:   t2[i] = sat_fn(ext32(s1_ctx.a[i]) + ext32(s1_b[i]));
        OP_SUB:   t2[i] = sat_fn(ext32(s1_ctx.a[i]) - ext32(s1_b[i]));
        OP_SCALE: t2[i] = round_fn(ext64(s1_p[i]));
        OP_CROSS: t2[i] = round_fn(ext64(s1_p[i]) - ext64(s1_p[3+i]));
        default: ;
      endcase
      c2.r[i] = t2[i][31:0];
      c2.sat  = c2.sat | t2[i][32];
    end
    if (s1_ctx.op == OP_DOT) begin
      c2.sc  = d2[31:0];
      c2.sat = d2[32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_st[0].n   <= sq2;
      sq_st[0].r   <= '0;
      sq_st[0].car <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= s1_v;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [PROD_W-1:0] BITK = 64'(1) << (62 - 2 * k);
    logic [PROD_W-1:0] trial;
    assign trial = sq_st[k].r + BITK;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_st[k+1].car <= sq_st[k].car;
        if (sq_st[k].n >= trial) begin
          sq_st[k+1].n <= sq_st[k].n - trial;
          sq_st[k+1].r <= (sq_st[k].r >> 1) + BITK;
        end else begin
          sq_st[k+1].n <= sq_st[k].n;
          sq_st[k+1].r <= sq_st[k].r >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
  end

  // divider setup
  dv_t                 dv   [QUOT_BITS+1];
  logic                dv_v [QUOT_BITS+1];
  dv_t                 dp;
  logic [WORD_W-1:0]   pm;
  logic [WORD_W-1:0]   pa;
  logic [WORD_W-1:0]   ps;
  car_t                pc;

  always_comb begin
    pc    = sq_st[SQRT_STEPS].car;
    pm    = sq_st[SQRT_STEPS].r[31:0];
    ps    = pc.ctx.s[31] ? (~pc.ctx.s + 32'd1) : pc.ctx.s;
    dp    = '0;
    dp.d  = (pc.ctx.op == OP_DIV) ? ps : pm;
    dp.mzero = (pm == '0);
    for (int i = 0; i < 3; i++) begin
      pa         = pc.ctx.a[i][31] ? (~pc.ctx.a[i] + 32'd1) : pc.ctx.a[i];
      dp.rem[i]  = {32'b0, pa} << FRAC_BITS;
      dp.ovf[i]  = dp.rem[i] >= {dp.d, 32'b0};
      dp.neg[i]  = pc.ctx.a[i][31] ^ ((pc.ctx.op == OP_DIV) && pc.ctx.s[31]);
    end
    if (pc.ctx.op == OP_MAG) begin
      if (pm > 32'h7fff_ffff) begin
        pc.sc  = 32'h7fff_ffff;
        pc.sat = 1'b1;
      end else begin
        pc.sc = pm;
      end
    end
    dp.car = pc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  // restoring division, one quotient bit per stage on three lanes
  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    logic [PROD_W-1:0] dd;
    dv_t               dv_next;

    assign dd = {32'b0, dv[j].d} << (QUOT_BITS - 1 - j);

    always_comb begin
      dv_next = dv[j];
      for (int i = 0; i < 3; i++) begin
        if (dv[j].rem[i] >= dd) begin
          dv_next.rem[i] = dv[j].rem[i] - dd;
          dv_next.q[i]   = {dv[j].q[i][QUOT_BITS-2:0], 1'b1};
        end else begin
          dv_next.q[i]   = {dv[j].q[i][QUOT_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j+1] <= dv_next;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
  end

  // final selection and output register
  dv_t                     fd;
  logic [2:0][WORD_W-1:0]  fr;
  logic [WORD_W-1:0]       fsc;
  logic                    fsat;
  status_t                 fst;

  always_comb begin
    fd   = dv[QUOT_BITS];
    fr   = fd.car.r;
    fsc  = fd.car.sc;
    fsat = fd.car.sat;
    fst  = ST_OK;
    if ((fd.car.ctx.op == OP_DIV) && fd.car.ctx.s_zero) begin
      fr  = fd.car.ctx.a;
      fst = ST_DIVZ;
    end else if ((fd.car.ctx.op == OP_NORM) && fd.mzero) begin
      fr = fd.car.ctx.a;
    end else if ((fd.car.ctx.op == OP_DIV) || (fd.car.ctx.op == OP_NORM)) begin
      for (int i = 0; i < 3; i++) begin
        if (fd.neg[i]) begin
          if (fd.ovf[i] || (fd.q[i] > 32'h8000_0000)) begin
            fr[i] = 32'h8000_0000;
            fsat  = 1'b1;
          end else begin
            fr[i] = ~fd.q[i] + 32'd1;
          end
        end else begin
          if (fd.ovf[i] || (fd.q[i] > 32'h7fff_ffff)) begin
            fr[i] = 32'h7fff_ffff;
            fsat  = 1'b1;
          end else begin
            fr[i] = fd.q[i];
          end
        end
      end
    end
    if ((fst == ST_OK) && fsat) begin
      fst = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {fsc, fr[2], fr[1], fr[0]};
      m_tuser <= fst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv_v[QUOT_BITS];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vector3_fixed_point_alu_core.sv @@
// top level of the 3d vector fixed point alu
//
//   port group  dir  tdata (low to high)                  tuser
//   s_axis      in   ax ay az bx by_comp bz scalar_in     cmd
//   m_axis      out  rx ry rz scalar_out                  status
//
// one transaction per cycle sustained while the output is not stalled;
// results pass the 32-stage square root and then the 32-stage divider
// reset clears only valid state and the queue pointers and count
// a stalled output holds the whole pipeline; the two-entry queue lets
// the input side go on taking transactions until the queue is full
`default_nettype none

module vector3_fixed_point_alu_core
  import vfa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // ax ay az bx by_comp bz scalar_in
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // cmd
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // rx ry rz scalar_out
  output logic [OUT_USER_W-1:0]      m_tuser    // status
);

  logic  q_wr;
  logic  q_full;
  logic  q_rd;
  logic  q_valid;
  item_t q_wdata;
  item_t q_rdata;

  vfa_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_wr     (q_wr),
    .q_item   (q_wdata),
    .q_full   (q_full)
  );

  vfa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  vfa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_rdata),
    .q_rd     (q_rd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
